[sv/pwu_pkg.sv]
// pwu_pkg: shared types, codes and constants of the particle weight update block
// no dependencies; imported by every pwu module
package pwu_pkg;

    // input transaction modes
    localparam logic [1:0] MODE_LANDMARK = 2'd0;
    localparam logic [1:0] MODE_OBSERVE  = 2'd1;
    localparam logic [1:0] MODE_PARTICLE = 2'd2;
    localparam logic [1:0] MODE_CLEAR    = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_VAR_X   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_VAR_Y   = 2'd2;

    localparam int RANGE_W = 31;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 31'd3276800;
    localparam logic [31:0]        INV_RESET   = 32'd364089;

    // result sum
    localparam int SUM_W = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    // digit-serial multiplier: 64 by 64 bits, 16 bits of b per cycle
    localparam int MUL_W      = 64;
    localparam int DIG_W      = 16;
    localparam int MUL_DIGITS = MUL_W / DIG_W;
    localparam int PROD_W     = 2 * MUL_W;

    // cordic datapath, Q2.30 vector and 2^-32 turn angle
    localparam int CORD_W       = 33;
    localparam int Z_W          = 34;
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [CORD_W-1:0] CORDIC_K = 33'sd652032874;

    typedef struct packed {
        logic                     valid;
        logic                     flip;
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } t_rot;

    // arctangent of 2^-step in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_turn(input int step);
        logic signed [Z_W-1:0] v;
        case (step)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/pwu_cordic_cell.sv]
// pwu_cordic_cell: one registered micro-rotation of the sine/cosine chain
// depends on pwu_pkg (t_rot, atan_turn)
module pwu_cordic_cell import pwu_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_rot i_rot,
    output t_rot o_rot
);

    localparam logic signed [Z_W-1:0] ATAN = atan_turn(STEP);

    logic signed [CORD_W-1:0] w_x, w_y, w_dx, w_dy;
    logic signed [Z_W-1:0]    w_z;
    t_rot                     r_rot;

    // flooring shifts of the incoming vector
    always_comb begin
        w_x  = i_rot.x;
        w_y  = i_rot.y;
        w_z  = i_rot.z;
        w_dx = w_y >>> STEP;
        w_dy = w_x >>> STEP;
    end

    // valid travels with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.valid <= 1'b0;
        end else begin
            r_rot.valid <= i_rot.valid;
        end
    end

    // rotate toward zero residual angle
    always_ff @(posedge i_clk) begin
        r_rot.flip <= i_rot.flip;
        if (w_z >= 0) begin
            r_rot.x <= w_x - w_dx;
            r_rot.y <= w_y + w_dy;
            r_rot.z <= w_z - ATAN;
        end else begin
            r_rot.x <= w_x + w_dx;
            r_rot.y <= w_y - w_dy;
            r_rot.z <= w_z + ATAN;
        end
    end

    assign o_rot = r_rot;

endmodule

[sv/pwu_cordic.sv]
// pwu_cordic: heading fold, chain of cordic cells and final sign fix
// depends on pwu_pkg and pwu_cordic_cell
module pwu_cordic import pwu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [15:0]              i_heading,
    output logic                     o_valid,
    output logic signed [CORD_W-1:0] o_cos,
    output logic signed [CORD_W-1:0] o_sin
);

    logic signed [16:0]       w_ang;
    logic signed [16:0]       w_fold;
    logic                     w_flip;
    t_rot                     w_rot [CORDIC_STEPS+1];
    t_rot                     r_head;
    logic                     r_valid;
    logic signed [CORD_W-1:0] r_cos, r_sin;

    // fold the heading into a quarter turn either side of zero
    always_comb begin
        w_ang  = 17'($signed(i_heading));
        w_fold = w_ang;
        w_flip = 1'b0;
        if (w_ang > 17'sd16384) begin
            w_fold = w_ang - 17'sd32768;
            w_flip = 1'b1;
        end else if (w_ang < -17'sd16384) begin
            w_fold = w_ang + 17'sd32768;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else begin
            r_head.valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head.flip <= w_flip;
        r_head.x    <= CORDIC_K;
        r_head.y    <= '0;
        r_head.z    <= Z_W'(w_fold) <<< 16;
    end

    assign w_rot[0] = r_head;

    // row of micro-rotation cells
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        pwu_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rot   (w_rot[g]),
            .o_rot   (w_rot[g+1])
        );
    end

    // undo the fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_rot[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos <= w_rot[CORDIC_STEPS].flip ? -w_rot[CORDIC_STEPS].x : w_rot[CORDIC_STEPS].x;
        r_sin <= w_rot[CORDIC_STEPS].flip ? -w_rot[CORDIC_STEPS].y : w_rot[CORDIC_STEPS].y;
    end

    assign o_valid = r_valid;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

[sv/pwu_mul.sv]
// pwu_mul: unsigned 64 by 64 multiplier, one 16-bit digit of b per cycle
// depends on pwu_pkg (MUL_W, DIG_W, MUL_DIGITS, PROD_W)
module pwu_mul import pwu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    localparam int CNT_W = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;
    localparam int PP_W  = MUL_W + DIG_W;

    logic [MUL_W-1:0] r_a, r_b, r_hi, r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [PP_W-1:0]  w_pp;
    logic             w_last;

    // partial product of one digit plus the running upper half
    assign w_pp   = PP_W'(r_a) * PP_W'(r_b[DIG_W-1:0]) + PP_W'(r_hi);
    assign w_last = (r_cnt == CNT_W'(MUL_DIGITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // digits leave at the bottom, low product fills from the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_hi <= w_pp[PP_W-1:DIG_W];
            r_lo <= {w_pp[DIG_W-1:0], r_lo[MUL_W-1:DIG_W]};
            r_b  <= r_b >> DIG_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

[sv/particle_weight_update.sv]
// Particle weight update. Landmark and observation transactions are stored in on-chip tables
// while there is room; a clear transaction empties both. A particle transaction returns one
// result: the sum of Gaussian exponents of nearest-landmark matches, plus a flag when no landmark
// lay inside the search square. The run time of a particle is set by the pair loop, where each
// in-range landmark costs one pass of the two shared digit-serial multipliers. Sine and cosine
// come from a chain of 16 cordic cells, with an entry and an exit register, that runs in
// parallel with the range scan. One particle is in work at a time; the next transaction is taken
// while a finished result waits in the output register.
// depends on pwu_pkg, pwu_cordic, pwu_mul
module particle_weight_update import pwu_pkg::*; #(
    parameter int MAX_LANDMARKS    = 64,
    parameter int MAX_OBSERVATIONS = 16,
    parameter int COORD_BITS       = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic [15:0]                  i_heading,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [SUM_W-1:0]             o_exponent_sum,
    output logic                         o_none_in_range,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]         i_cfg_data
);

    localparam int LCW   = $clog2(MAX_LANDMARKS + 1);
    localparam int LIW   = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int OCW   = $clog2(MAX_OBSERVATIONS + 1);
    localparam int OIW   = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
    localparam int EX_W  = (COORD_BITS + 1 > 32) ? COORD_BITS + 1 : 32;
    localparam int RP_W  = COORD_BITS + 32;
    localparam int RM_W  = RP_W - 29;
    localparam int RT_W  = RM_W + 1;
    localparam int MX_W  = COORD_BITS + 3;
    localparam int D_W   = COORD_BITS + 4;
    localparam int SQ_W  = 2 * D_W;
    localparam int D2_W  = SQ_W + 1;
    localparam int SS_W  = SUM_W + 2;

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RNG_RD   = 5'd1;
    localparam logic [4:0] S_RNG_SUB  = 5'd2;
    localparam logic [4:0] S_RNG_CMP  = 5'd3;
    localparam logic [4:0] S_TRIG     = 5'd4;
    localparam logic [4:0] S_OBS_RD   = 5'd5;
    localparam logic [4:0] S_ROTA_GO  = 5'd6;
    localparam logic [4:0] S_ROTA_WT  = 5'd7;
    localparam logic [4:0] S_ROTA_ACC = 5'd8;
    localparam logic [4:0] S_ROTB_GO  = 5'd9;
    localparam logic [4:0] S_ROTB_WT  = 5'd10;
    localparam logic [4:0] S_ROTB_ACC = 5'd11;
    localparam logic [4:0] S_PR_RD    = 5'd12;
    localparam logic [4:0] S_PR_SUB   = 5'd13;
    localparam logic [4:0] S_PR_GO    = 5'd14;
    localparam logic [4:0] S_PR_WT    = 5'd15;
    localparam logic [4:0] S_PR_CMP   = 5'd16;
    localparam logic [4:0] S_EXP_GO   = 5'd17;
    localparam logic [4:0] S_EXP_WT   = 5'd18;
    localparam logic [4:0] S_EXP_ADD  = 5'd19;
    localparam logic [4:0] S_DONE     = 5'd20;

    logic [4:0]                  r_state;
    logic [RANGE_W-1:0]          r_range_limit;
    logic [31:0]                 r_inv_x, r_inv_y;
    logic [LCW-1:0]              r_lm_cnt, r_j;
    logic [OCW-1:0]              r_obs_cnt, r_i;

    logic signed [COORD_BITS-1:0] r_lm_x_mem  [MAX_LANDMARKS];
    logic signed [COORD_BITS-1:0] r_lm_y_mem  [MAX_LANDMARKS];
    logic signed [COORD_BITS-1:0] r_obs_x_mem [MAX_OBSERVATIONS];
    logic signed [COORD_BITS-1:0] r_obs_y_mem [MAX_OBSERVATIONS];
    logic signed [COORD_BITS-1:0] r_lx_q, r_ly_q, r_ox_q, r_oy_q;

    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic signed [CORD_W-1:0]     r_cos, r_sin;
    logic                         r_trig_ok, r_any, r_found;
    logic                         r_negx, r_negy;
    logic signed [RT_W-1:0]       r_rt_x, r_rt_y;
    logic signed [MX_W-1:0]       r_mx, r_my;
    logic signed [EX_W-1:0]       r_ex, r_ey;
    logic signed [D_W-1:0]        r_dx, r_dy;
    logic [SQ_W-1:0]              r_sqx, r_sqy, r_bsqx, r_bsqy;
    logic [D2_W-1:0]              r_d2, r_best;
    logic [SUM_W-1:0]             r_term_x, r_term_y, r_sum;
    logic                         r_ovalid, r_out_none;
    logic [SUM_W-1:0]             r_out_sum;

    logic                     w_acc;
    logic                     w_cord_valid;
    logic signed [CORD_W-1:0] w_cord_cos, w_cord_sin;
    logic [31:0]              w_cos_mag, w_sin_mag;
    logic [COORD_BITS-1:0]    w_ox_mag, w_oy_mag;
    logic [D_W-1:0]           w_dx_mag, w_dy_mag;
    logic signed [EX_W-1:0]   w_lim;
    logic                     w_in_range;
    logic                     w_start;
    logic [MUL_W-1:0]         w_ax, w_bx, w_ay, w_by;
    logic                     w_done_x, w_done_y;
    logic [PROD_W-1:0]        w_prod_x, w_prod_y;
    logic [RP_W:0]            w_rnd_x, w_rnd_y;
    logic [RM_W-1:0]          w_rm_x, w_rm_y;
    logic signed [RT_W-1:0]   w_rt_x, w_rt_y;
    logic [PROD_W-1:0]        w_bsqx_ext, w_bsqy_ext;
    logic [SUM_W-1:0]         w_term_x, w_term_y;
    logic [SS_W-1:0]          w_sum3;
    logic                     w_lm_last, w_obs_last;

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // sine and cosine of the particle heading
    pwu_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_acc && (i_mode == MODE_PARTICLE)),
        .i_heading (i_heading),
        .o_valid   (w_cord_valid),
        .o_cos     (w_cord_cos),
        .o_sin     (w_cord_sin)
    );

    // table storage with registered reads
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_mode == MODE_LANDMARK) && (r_lm_cnt < LCW'(MAX_LANDMARKS))) begin
            r_lm_x_mem[r_lm_cnt[LIW-1:0]] <= i_coord_x;
            r_lm_y_mem[r_lm_cnt[LIW-1:0]] <= i_coord_y;
        end
        if (w_acc && (i_mode == MODE_OBSERVE) && (r_obs_cnt < OCW'(MAX_OBSERVATIONS))) begin
            r_obs_x_mem[r_obs_cnt[OIW-1:0]] <= i_coord_x;
            r_obs_y_mem[r_obs_cnt[OIW-1:0]] <= i_coord_y;
        end
        r_lx_q <= r_lm_x_mem[r_j[LIW-1:0]];
        r_ly_q <= r_lm_y_mem[r_j[LIW-1:0]];
        r_ox_q <= r_obs_x_mem[r_i[OIW-1:0]];
        r_oy_q <= r_obs_y_mem[r_i[OIW-1:0]];
    end

    // magnitudes and range test
    always_comb begin
        w_cos_mag  = 32'(r_cos[CORD_W-1] ? -r_cos : r_cos);
        w_sin_mag  = 32'(r_sin[CORD_W-1] ? -r_sin : r_sin);
        w_ox_mag   = COORD_BITS'(r_ox_q[COORD_BITS-1] ? -r_ox_q : r_ox_q);
        w_oy_mag   = COORD_BITS'(r_oy_q[COORD_BITS-1] ? -r_oy_q : r_oy_q);
        w_dx_mag   = D_W'(r_dx[D_W-1] ? -r_dx : r_dx);
        w_dy_mag   = D_W'(r_dy[D_W-1] ? -r_dy : r_dy);
        w_lim      = $signed(EX_W'(r_range_limit));
        w_in_range = (r_ex <= w_lim) && (r_ex >= -w_lim) &&
                     (r_ey <= w_lim) && (r_ey >= -w_lim);
        w_lm_last  = ((r_j + LCW'(1)) == r_lm_cnt);
        w_obs_last = ((r_i + OCW'(1)) == r_obs_cnt);
    end

    // multiplier operand selection
    always_comb begin
        w_start = 1'b0;
        w_ax    = '0;
        w_bx    = '0;
        w_ay    = '0;
        w_by    = '0;
        case (r_state)
            S_ROTA_GO: begin
                w_start = 1'b1;
                w_ax    = MUL_W'(w_ox_mag);
                w_bx    = MUL_W'(w_cos_mag);
                w_ay    = MUL_W'(w_oy_mag);
                w_by    = MUL_W'(w_sin_mag);
            end
            S_ROTB_GO: begin
                w_start = 1'b1;
                w_ax    = MUL_W'(w_ox_mag);
                w_bx    = MUL_W'(w_sin_mag);
                w_ay    = MUL_W'(w_oy_mag);
                w_by    = MUL_W'(w_cos_mag);
            end
            S_PR_GO: begin
                w_start = w_in_range;
                w_ax    = MUL_W'(w_dx_mag);
                w_bx    = MUL_W'(w_dx_mag);
                w_ay    = MUL_W'(w_dy_mag);
                w_by    = MUL_W'(w_dy_mag);
            end
            S_EXP_GO: begin
                w_start = 1'b1;
                w_ax    = w_bsqx_ext[MUL_W-1:0];
                w_bx    = MUL_W'(r_inv_x);
                w_ay    = w_bsqy_ext[MUL_W-1:0];
                w_by    = MUL_W'(r_inv_y);
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    pwu_mul u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_ax),
        .i_b     (w_bx),
        .o_done  (w_done_x),
        .o_prod  (w_prod_x)
    );

    pwu_mul u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_ay),
        .i_b     (w_by),
        .o_done  (w_done_y),
        .o_prod  (w_prod_y)
    );

    // round half up of the rotation products, worked on the magnitude
    always_comb begin
        w_rnd_x = {1'b0, w_prod_x[RP_W-1:0]} +
                  (RP_W+1)'(r_negx ? 30'h1FFF_FFFF : 30'h2000_0000);
        w_rnd_y = {1'b0, w_prod_y[RP_W-1:0]} +
                  (RP_W+1)'(r_negy ? 30'h1FFF_FFFF : 30'h2000_0000);
        w_rm_x  = w_rnd_x[RP_W:30];
        w_rm_y  = w_rnd_y[RP_W:30];
        w_rt_x  = r_negx ? -$signed({1'b0, w_rm_x}) : $signed({1'b0, w_rm_x});
        w_rt_y  = r_negy ? -$signed({1'b0, w_rm_y}) : $signed({1'b0, w_rm_y});
    end

    // exponent terms, saturated
    always_comb begin
        w_bsqx_ext = PROD_W'(r_bsqx);
        w_bsqy_ext = PROD_W'(r_bsqy);
        if (|w_bsqx_ext[PROD_W-1:MUL_W]) begin
            w_term_x = (r_inv_x != '0) ? SUM_MAX : '0;
        end else if (|w_prod_x[PROD_W-1:SUM_W+32]) begin
            w_term_x = SUM_MAX;
        end else begin
            w_term_x = w_prod_x[SUM_W+31:32];
        end
        if (|w_bsqy_ext[PROD_W-1:MUL_W]) begin
            w_term_y = (r_inv_y != '0) ? SUM_MAX : '0;
        end else if (|w_prod_y[PROD_W-1:SUM_W+32]) begin
            w_term_y = SUM_MAX;
        end else begin
            w_term_y = w_prod_y[SUM_W+31:32];
        end
        w_sum3 = SS_W'(r_sum) + SS_W'(r_term_x) + SS_W'(r_term_y);
    end

    // control: configuration, counts, sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_range_limit <= RANGE_RESET;
            r_inv_x       <= INV_RESET;
            r_inv_y       <= INV_RESET;
            r_lm_cnt      <= '0;
            r_obs_cnt     <= '0;
            r_j           <= '0;
            r_i           <= '0;
            r_trig_ok     <= 1'b0;
            r_any         <= 1'b0;
            r_found       <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RANGE_LIMIT: r_range_limit <= i_cfg_data[RANGE_W-1:0];
                    CFG_INV_VAR_X:   r_inv_x       <= i_cfg_data;
                    CFG_INV_VAR_Y:   r_inv_y       <= i_cfg_data;
                    default:         r_inv_x       <= r_inv_x;
                endcase
            end
            // trig ready flag, cleared when a particle is taken
            if (w_cord_valid) begin
                r_trig_ok <= 1'b1;
            end else if (w_acc && (i_mode == MODE_PARTICLE)) begin
                r_trig_ok <= 1'b0;
            end
            // output register fills from the done state, empties on a taken transaction
            if ((r_state == S_DONE) && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_mode)
                            MODE_LANDMARK: begin
                                if (r_lm_cnt < LCW'(MAX_LANDMARKS)) begin
                                    r_lm_cnt <= r_lm_cnt + LCW'(1);
                                end
                            end
                            MODE_OBSERVE: begin
                                if (r_obs_cnt < OCW'(MAX_OBSERVATIONS)) begin
                                    r_obs_cnt <= r_obs_cnt + OCW'(1);
                                end
                            end
                            MODE_PARTICLE: begin
                                r_any     <= 1'b0;
                                r_j       <= '0;
                                r_state   <= (r_lm_cnt == '0) ? S_TRIG : S_RNG_RD;
                            end
                            default: begin
                                r_lm_cnt  <= '0;
                                r_obs_cnt <= '0;
                            end
                        endcase
                    end
                end
                S_RNG_RD: begin
                    r_state <= S_RNG_SUB;
                end
                S_RNG_SUB: begin
                    r_state <= S_RNG_CMP;
                end
                S_RNG_CMP: begin
                    if (w_in_range) begin
                        r_any <= 1'b1;
                    end
                    if (w_lm_last) begin
                        r_state <= S_TRIG;
                    end else begin
                        r_j     <= r_j + LCW'(1);
                        r_state <= S_RNG_RD;
                    end
                end
                S_TRIG: begin
                    if (r_trig_ok) begin
                        r_i <= '0;
                        if (r_obs_cnt == '0) begin
                            r_state <= S_DONE;
                        end else if (!r_any) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_OBS_RD;
                        end
                    end
                end
                S_OBS_RD: begin
                    r_state <= S_ROTA_GO;
                end
                S_ROTA_GO: begin
                    r_state <= S_ROTA_WT;
                end
                S_ROTA_WT: begin
                    if (w_done_x && w_done_y) begin
                        r_state <= S_ROTA_ACC;
                    end
                end
                S_ROTA_ACC: begin
                    r_state <= S_ROTB_GO;
                end
                S_ROTB_GO: begin
                    r_state <= S_ROTB_WT;
                end
                S_ROTB_WT: begin
                    if (w_done_x && w_done_y) begin
                        r_state <= S_ROTB_ACC;
                    end
                end
                S_ROTB_ACC: begin
                    r_j     <= '0;
                    r_found <= 1'b0;
                    r_state <= S_PR_RD;
                end
                S_PR_RD: begin
                    r_state <= S_PR_SUB;
                end
                S_PR_SUB: begin
                    r_state <= S_PR_GO;
                end
                S_PR_GO: begin
                    if (w_in_range) begin
                        r_state <= S_PR_WT;
                    end else if (w_lm_last) begin
                        r_state <= S_EXP_GO;
                    end else begin
                        r_j     <= r_j + LCW'(1);
                        r_state <= S_PR_RD;
                    end
                end
                S_PR_WT: begin
                    if (w_done_x && w_done_y) begin
                        r_state <= S_PR_CMP;
                    end
                end
                S_PR_CMP: begin
                    if (!r_found || (r_d2 < r_best)) begin
                        r_found <= 1'b1;
                    end
                    if (w_lm_last) begin
                        r_state <= S_EXP_GO;
                    end else begin
                        r_j     <= r_j + LCW'(1);
                        r_state <= S_PR_RD;
                    end
                end
                S_EXP_GO: begin
                    r_state <= S_EXP_WT;
                end
                S_EXP_WT: begin
                    if (w_done_x && w_done_y) begin
                        r_state <= S_EXP_ADD;
                    end
                end
                S_EXP_ADD: begin
                    if (w_obs_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + OCW'(1);
                        r_state <= S_OBS_RD;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_cord_valid) begin
            r_cos <= w_cord_cos;
            r_sin <= w_cord_sin;
        end
        case (r_state)
            S_IDLE: begin
                r_px <= i_coord_x;
                r_py <= i_coord_y;
            end
            S_RNG_SUB, S_PR_SUB: begin
                r_ex <= EX_W'(r_px) - EX_W'(r_lx_q);
                r_ey <= EX_W'(r_py) - EX_W'(r_ly_q);
                r_dx <= D_W'(r_mx) - D_W'(r_lx_q);
                r_dy <= D_W'(r_my) - D_W'(r_ly_q);
            end
            S_TRIG: begin
                r_sum <= ((r_obs_cnt != '0) && !r_any) ? SUM_MAX : '0;
            end
            S_ROTA_GO: begin
                r_negx <= r_ox_q[COORD_BITS-1] ^ r_cos[CORD_W-1];
                r_negy <= r_oy_q[COORD_BITS-1] ^ r_sin[CORD_W-1];
            end
            S_ROTB_GO: begin
                r_negx <= r_ox_q[COORD_BITS-1] ^ r_sin[CORD_W-1];
                r_negy <= r_oy_q[COORD_BITS-1] ^ r_cos[CORD_W-1];
            end
            S_ROTA_WT, S_ROTB_WT: begin
                r_rt_x <= w_rt_x;
                r_rt_y <= w_rt_y;
            end
            S_ROTA_ACC: begin
                r_mx <= MX_W'(r_px) + MX_W'(r_rt_x) - MX_W'(r_rt_y);
            end
            S_ROTB_ACC: begin
                r_my <= MX_W'(r_py) + MX_W'(r_rt_x) + MX_W'(r_rt_y);
            end
            S_PR_WT: begin
                r_sqx <= w_prod_x[SQ_W-1:0];
                r_sqy <= w_prod_y[SQ_W-1:0];
                r_d2  <= D2_W'(w_prod_x[SQ_W-1:0]) + D2_W'(w_prod_y[SQ_W-1:0]);
            end
            S_PR_CMP: begin
                if (!r_found || (r_d2 < r_best)) begin
                    r_best <= r_d2;
                    r_bsqx <= r_sqx;
                    r_bsqy <= r_sqy;
                end
            end
            S_EXP_WT: begin
                r_term_x <= w_term_x;
                r_term_y <= w_term_y;
            end
            S_EXP_ADD: begin
                r_sum <= (w_sum3 > SS_W'(SUM_MAX)) ? SUM_MAX : w_sum3[SUM_W-1:0];
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    r_out_sum  <= r_sum;
                    r_out_none <= !r_any;
                end
            end
            default: begin
                r_px <= r_px;
            end
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_exponent_sum  = r_out_sum;
    assign o_none_in_range = r_out_none;

endmodule

[tb/particle_weight_update_tb.sv]
// particle_weight_update_tb: self-checking testbench of the particle weight update block
// predicts each particle result with its own fixed-point model; depends on pwu_pkg and the rtl
`timescale 1ns / 100ps

module particle_weight_update_tb;
    import pwu_pkg::*;

    localparam int NUM_LM     = 64;
    localparam int NUM_OBS    = 16;
    localparam int CYCLE_CAP  = 10000000;
    localparam int SETTLE_CYC = 20;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             none;
    } t_weight;

    // scoreboard: tables, registers and a queue of expected weights
    class weight_scoreboard;
        longint         lm_x[NUM_LM], lm_y[NUM_LM];
        longint         ob_x[NUM_OBS], ob_y[NUM_OBS];
        int             lm_cnt, ob_cnt;
        longint         range_lim;
        logic [31:0]    inv_x, inv_y;
        t_weight        weights_due[$];
        int             errors;
        longint         atan_tab[16];

        function new();
            atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772,
                         166886, 83443, 41722, 20861};
            range_lim = RANGE_RESET;
            inv_x     = INV_RESET;
            inv_y     = INV_RESET;
            lm_cnt    = 0;
            ob_cnt    = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_RANGE_LIMIT: range_lim = val[30:0];
                CFG_INV_VAR_X:   inv_x = val;
                CFG_INV_VAR_Y:   inv_y = val;
                default: ;
            endcase
        endfunction

        // q2.30 cosine and sine of a binary angle
        function void sin_cos(logic [15:0] hd, output longint c, output longint s);
            longint a, x, y, z, dx, dy;
            bit     flip;
            a = longint'(hd);
            flip = 0;
            if (a >= 32768) a -= 65536;
            if (a > 16384) begin
                a -= 32768;
                flip = 1;
            end else if (a < -16384) begin
                a += 32768;
                flip = 1;
            end
            x = 652032874;
            y = 0;
            z = a * 65536;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // a*b/2^30 rounded half up
        function longint rot_term(longint a, longint b);
            logic signed [127:0] aw, bw, p;
            aw = a;
            bw = b;
            p = aw * bw + (128'sd1 <<< 29);
            return longint'(p >>> 30);
        endfunction

        function logic [127:0] square(longint d);
            logic [127:0] m;
            m = (d < 0) ? 128'(-d) : 128'(d);
            return m * m;
        endfunction

        function logic [SUM_W-1:0] gauss_term(longint d, logic [31:0] inv);
            logic [127:0] sq;
            logic [95:0]  v;
            sq = square(d);
            if (sq[127:64] != 0) return (inv != 0) ? SUM_MAX : '0;
            v = (96'(sq[63:0]) * 96'(inv)) >> 32;
            return (v > 96'(SUM_MAX)) ? SUM_MAX : v[SUM_W-1:0];
        endfunction

        function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [SUM_W:0] s;
            s = a + b;
            return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        function bit in_square(longint px, longint py, int j);
            longint ex, ey;
            ex = px - lm_x[j];
            ey = py - lm_y[j];
            return ex <= range_lim && ex >= -range_lim && ey <= range_lim && ey >= -range_lim;
        endfunction

        function t_weight weigh_particle(longint px, longint py, logic [15:0] hd);
            t_weight        w;
            bit             any, found;
            longint         c, s, mx, my, bdx, bdy;
            logic [128:0]   sq_dist, best;
            any = 0;
            for (int j = 0; j < lm_cnt; j++) if (in_square(px, py, j)) any = 1;
            w.none = !any;
            w.sum = '0;
            sin_cos(hd, c, s);
            for (int i = 0; i < ob_cnt; i++) begin
                if (!any) begin
                    w.sum = SUM_MAX;
                    break;
                end
                mx = px + rot_term(ob_x[i], c) - rot_term(ob_y[i], s);
                my = py + rot_term(ob_x[i], s) + rot_term(ob_y[i], c);
                found = 0;
                best = '0;
                bdx = 0;
                bdy = 0;
                for (int j = 0; j < lm_cnt; j++) begin
                    if (!in_square(px, py, j)) continue;
                    sq_dist = 129'(square(mx - lm_x[j])) + 129'(square(my - lm_y[j]));
                    if (!found || sq_dist < best) begin
                        found = 1;
                        best = sq_dist;
                        bdx = mx - lm_x[j];
                        bdy = my - lm_y[j];
                    end
                end
                w.sum = sat_add(w.sum, gauss_term(bdx, inv_x));
                w.sum = sat_add(w.sum, gauss_term(bdy, inv_y));
            end
            return w;
        endfunction

        // accepted input transaction
        function void note_input(logic [1:0] md, logic signed [31:0] cx,
                                 logic signed [31:0] cy, logic [15:0] hd);
            longint px, py;
            px = cx;
            py = cy;
            case (md)
                MODE_LANDMARK: if (lm_cnt < NUM_LM) begin
                    lm_x[lm_cnt] = px;
                    lm_y[lm_cnt] = py;
                    lm_cnt++;
                end
                MODE_OBSERVE: if (ob_cnt < NUM_OBS) begin
                    ob_x[ob_cnt] = px;
                    ob_y[ob_cnt] = py;
                    ob_cnt++;
                end
                MODE_CLEAR: begin
                    lm_cnt = 0;
                    ob_cnt = 0;
                end
                default: weights_due.insert(weights_due.size(), weigh_particle(px, py, hd));
            endcase
        endfunction

        // accepted result transaction
        function void check_result(logic [SUM_W-1:0] sum, logic none);
            t_weight w;
            if (weights_due.size() == 0) begin
                $error("unexpected result: exponent_sum %0d none_in_range %0d", sum, none);
                errors++;
                return;
            end
            w = weights_due.pop_front();
            if (sum !== w.sum) begin
                $error("exponent_sum expected %0d actual %0d", w.sum, sum);
                errors++;
            end
            if (none !== w.none) begin
                $error("none_in_range expected %0d actual %0d", w.none, none);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_valid = 0;
    logic                   o_stall;
    logic [1:0]             i_mode = MODE_CLEAR;
    logic signed [31:0]     i_coord_x = '0;
    logic signed [31:0]     i_coord_y = '0;
    logic [15:0]            i_heading = '0;
    logic                   o_valid;
    logic                   i_stall = 0;
    logic [SUM_W-1:0]       o_exponent_sum;
    logic                   o_none_in_range;
    logic                   i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_RANGE_LIMIT;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    weight_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  items_sent = 0;
    int  cycles = 0;

    particle_weight_update uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall
    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_stall_pct);

    // result monitor
    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_exponent_sum, o_none_in_range);

    // one input transaction; entered and left at a falling edge
    task automatic send(logic [1:0] md, logic [31:0] cx, logic [31:0] cy, logic [15:0] hd);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid = 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_mode = md;
        i_coord_x = cx;
        i_coord_y = cy;
        i_heading = hd;
        i_valid = 1;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(md, cx, cy, hd);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.set_reg(idx, val);
    endtask

    // hold input until every pending weight is back and loads have settled
    task automatic drain();
        i_valid = 0;
        while (sb.weights_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int spread);
        return base + $signed($urandom_range(2 * spread)) - spread;
    endfunction

    // one map: mostly a clear, landmarks, observations, then particles around it, now and then a random transaction
    task automatic run_map();
        logic [31:0] cx, cy;
        int nl, no, np, spread;
        bit wide;
        wide = ($urandom_range(9) == 0);
        cx = wide ? $urandom() : near(0, 1 << 24);
        cy = wide ? $urandom() : near(0, 1 << 24);
        spread = 1 << $urandom_range(16, 22);
        nl = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        no = ($urandom_range(19) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
        np = $urandom_range(1, 4);
        if ($urandom_range(3) != 0) send(MODE_CLEAR, $urandom(), $urandom(), 16'($urandom()));
        for (int k = 0; k < nl; k++)
            send(MODE_LANDMARK, near(cx, spread), near(cy, spread), 16'($urandom()));
        for (int k = 0; k < no; k++)
            send(MODE_OBSERVE, near(0, spread), near(0, spread), 16'($urandom()));
        for (int k = 0; k < np; k++) begin
            if ($urandom_range(7) == 0)
                send(2'($urandom_range(3)), $urandom(), $urandom(), 16'($urandom()));
            send(MODE_PARTICLE, near(cx, spread), near(cy, spread), 16'($urandom()));
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty tables, extremes, quadrant headings, ties
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'h0);
        send(MODE_LANDMARK, 32'h0001_0000, 32'h0002_0000, 16'h0);
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'h0);
        send(MODE_LANDMARK, 32'h0001_0000, 32'h0002_0000, 16'h0);
        send(MODE_OBSERVE, 32'h0001_0000, 32'h0, 16'h0);
        send(MODE_OBSERVE, 32'hFFFF_8000, 32'h0003_0000, 16'h0);
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'd0);
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'd16384);
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'd32768);
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'd49152);
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'hFFFF);
        send(MODE_PARTICLE, 32'h7FFF_FFFF, 32'h8000_0000, 16'd8192);
        send(MODE_CLEAR, 32'h0, 32'h0, 16'h0);
        send(MODE_LANDMARK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0);
        send(MODE_LANDMARK, 32'h8000_0000, 32'h8000_0000, 16'h0);
        send(MODE_OBSERVE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
        send(MODE_PARTICLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd40000);
        send(MODE_PARTICLE, 32'h8000_0000, 32'h8000_0000, 16'd24576);
        send(MODE_CLEAR, 32'h0, 32'h0, 16'h0);
        send(MODE_LANDMARK, 32'h0, 32'h0, 16'h0);
        send(MODE_PARTICLE, 32'h0, 32'h0, 16'h0);
        drain();

        // random phases, each with its own register setting and idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_RANGE_LIMIT, 32'(RANGE_RESET));
                    write_reg(CFG_INV_VAR_X, INV_RESET);
                    write_reg(CFG_INV_VAR_Y, INV_RESET);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    write_reg(CFG_RANGE_LIMIT, 32'h7FFF_FFFF);
                    write_reg(CFG_INV_VAR_X, 32'hFFFF_FFFF);
                    write_reg(CFG_INV_VAR_Y, 32'h0);
                    send_idle_pct = 58; recv_stall_pct = 0;
                end
                2: begin
                    write_reg(CFG_RANGE_LIMIT, 32'h0);
                    write_reg(CFG_INV_VAR_X, 32'h0);
                    write_reg(CFG_INV_VAR_Y, 32'hFFFF_FFFF);
                    send_idle_pct = 0;  recv_stall_pct = 58;
                end
                default: begin
                    write_reg(CFG_RANGE_LIMIT, $urandom_range(1 << 18, 1 << 24));
                    write_reg(CFG_INV_VAR_X, $urandom_range(1 << 12, 1 << 20));
                    write_reg(CFG_INV_VAR_Y, $urandom_range(1 << 12, 1 << 20));
                    send_idle_pct = 38; recv_stall_pct = 38;
                end
            endcase
            while (items_sent < 21 + (ph + 1) * 133) run_map();
            drain();
        end

        recv_stall_pct = 0;
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.weights_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
